// ===== hw/rtl/sbe_pkg.sv =====
// Package for the stack bytecode executor: opcodes, status codes, decode table,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package sbe_pkg;

    localparam int STACK_DEPTH_DEF = 512;
    localparam int DATA_WORDS_DEF  = 1024;
    localparam int CODE_BYTES_DEF  = 1024;

    localparam logic [7:0] OPC_NOP    = 8'h00;
    localparam logic [7:0] OPC_PUSH   = 8'h01;
    localparam logic [7:0] OPC_ADD    = 8'h02;
    localparam logic [7:0] OPC_SUB    = 8'h03;
    localparam logic [7:0] OPC_MUL    = 8'h04;
    localparam logic [7:0] OPC_DIV    = 8'h05;
    localparam logic [7:0] OPC_POW    = 8'h06;
    localparam logic [7:0] OPC_ABS    = 8'h07;
    localparam logic [7:0] OPC_NEG    = 8'h08;
    localparam logic [7:0] OPC_EVEN   = 8'h09;
    localparam logic [7:0] OPC_ODD    = 8'h0A;
    localparam logic [7:0] OPC_NONNEG = 8'h0B;
    localparam logic [7:0] OPC_ISNEG  = 8'h0C;
    localparam logic [7:0] OPC_DVSBL  = 8'h0D;
    localparam logic [7:0] OPC_REM    = 8'h0E;
    localparam logic [7:0] OPC_CLAMP  = 8'h0F;
    localparam logic [7:0] OPC_RAND   = 8'h10;
    localparam logic [7:0] OPC_EQ     = 8'h11;
    localparam logic [7:0] OPC_NE     = 8'h12;
    localparam logic [7:0] OPC_LT     = 8'h13;
    localparam logic [7:0] OPC_LE     = 8'h14;
    localparam logic [7:0] OPC_GT     = 8'h15;
    localparam logic [7:0] OPC_GE     = 8'h16;
    localparam logic [7:0] OPC_NOT    = 8'h19;
    localparam logic [7:0] OPC_NULL   = 8'h1A;
    localparam logic [7:0] OPC_GET    = 8'h1B;
    localparam logic [7:0] OPC_SET    = 8'h1C;
    localparam logic [7:0] OPC_JZ     = 8'h1D;
    localparam logic [7:0] OPC_JMP    = 8'h1E;
    localparam logic [7:0] OPC_PRINT  = 8'h1F;
    localparam logic [7:0] OPC_BOOL   = 8'h20;
    localparam logic [7:0] OPC_STOP   = 8'h21;
    localparam logic [7:0] OPC_JNZ    = 8'h22;
    localparam logic [7:0] OPC_CHG    = 8'h23;
    localparam logic [7:0] OPC_AND    = 8'h24;
    localparam logic [7:0] OPC_OR     = 8'h25;
    localparam logic [7:0] OPC_PINM   = 8'h26;
    localparam logic [7:0] OPC_DRD    = 8'h27;
    localparam logic [7:0] OPC_DWR    = 8'h28;
    localparam logic [7:0] OPC_ARD    = 8'h29;
    localparam logic [7:0] OPC_AWR    = 8'h2A;
    localparam logic [7:0] OPC_DELAY  = 8'h2B;

    localparam logic [7:0] BOOL_TRUE  = 8'h17;
    localparam logic [7:0] BOOL_FALSE = 8'h18;

    localparam logic [3:0] ST_RUN   = 4'd0;
    localparam logic [3:0] ST_STOP  = 4'd1;
    localparam logic [3:0] ST_END   = 4'd2;
    localparam logic [3:0] ST_OVF   = 4'd3;
    localparam logic [3:0] ST_UNF   = 4'd4;
    localparam logic [3:0] ST_ZDIV  = 4'd5;
    localparam logic [3:0] ST_ADDR  = 4'd6;
    localparam logic [3:0] ST_BOOL  = 4'd7;
    localparam logic [3:0] ST_NEG   = 4'd8;
    localparam logic [3:0] ST_OPC   = 4'd9;

    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_PRINT = 3'd1;
    localparam logic [2:0] K_PINM  = 3'd2;
    localparam logic [2:0] K_DRD   = 3'd3;
    localparam logic [2:0] K_DWR   = 3'd4;
    localparam logic [2:0] K_ARD   = 3'd5;
    localparam logic [2:0] K_AWR   = 3'd6;
    localparam logic [2:0] K_DELAY = 3'd7;

    typedef struct packed {
        logic       valid;
        logic [1:0] pops;
        logic       push;
        logic [1:0] len;
        logic       uses_addr;
    } t_opinfo;

    function automatic t_opinfo op_decode(input logic [7:0] op);
        t_opinfo d;
        d = '{valid: 1'b1, pops: 2'd0, push: 1'b0, len: 2'd1, uses_addr: 1'b0};
        case (op)
            OPC_NOP, OPC_STOP: ;
            OPC_PUSH: begin d.push = 1'b1; d.len = 2'd3; end
            OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_POW, OPC_DVSBL, OPC_REM,
            OPC_EQ, OPC_NE, OPC_LT, OPC_LE, OPC_GT, OPC_GE, OPC_AND, OPC_OR: begin
                d.pops = 2'd2; d.push = 1'b1;
            end
            OPC_ABS, OPC_NEG, OPC_EVEN, OPC_ODD, OPC_NONNEG, OPC_ISNEG, OPC_NOT: begin
                d.pops = 2'd1; d.push = 1'b1;
            end
            OPC_CLAMP: begin d.pops = 2'd3; d.push = 1'b1; end
            OPC_RAND, OPC_NULL: d.push = 1'b1;
            OPC_GET: begin d.push = 1'b1; d.len = 2'd3; d.uses_addr = 1'b1; end
            OPC_SET, OPC_CHG, OPC_PINM, OPC_DWR, OPC_AWR: begin
                d.pops = 2'd1; d.len = 2'd3; d.uses_addr = 1'b1;
            end
            OPC_DRD, OPC_ARD: begin d.len = 2'd3; d.uses_addr = 1'b1; end
            OPC_JZ, OPC_JNZ: begin d.pops = 2'd1; d.len = 2'd3; end
            OPC_JMP: d.len = 2'd3;
            OPC_PRINT, OPC_DELAY: d.pops = 2'd1;
            OPC_BOOL: begin d.push = 1'b1; d.len = 2'd2; end
            default: d.valid = 1'b0;
        endcase
        return d;
    endfunction

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD0, S_RD1, S_RD2, S_WAITRD, S_CHECK,
        S_ITER, S_EXEC, S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       clr_mem;
        logic       load;
        logic       rd_stack;
        logic [1:0] rd_depth;
        logic       cap_a;
        logic       cap_b;
        logic       cap_c;
        logic       cap_mem;
        logic       iter_start;
        logic       iter_step;
        logic       commit;
        logic       fault;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       clr_done;
        logic       halted;
        logic       pre_err;
        logic       post_err;
        logic       needs_iter;
        logic       iter_done;
        logic [1:0] pops;
    } t_sts;

endpackage

// ===== hw/rtl/stack_bytecode_executor.sv =====
// Stack bytecode executor: one instruction per input beat, one result beat each.
// Plain ops read operands off the stack; divide, and power with exponent >= 0, iterate.
// One item at a time: a new beat is taken only after the last result beat is accepted.
// Reset (i_rst_n low, synchronous) clears pc, stack level and halt code, then a
// clearing pass zeroes data memory before the first beat is taken.
`timescale 1ns / 1ps

module stack_bytecode_executor #(
    parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WORDS  = sbe_pkg::DATA_WORDS_DEF,
    parameter int CODE_BYTES  = sbe_pkg::CODE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_req_type,
    input  logic [15:0]        i_arg,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [9:0]         o_next_ip,
    output logic [3:0]         o_status,
    output logic [2:0]         o_out_kind,
    output logic signed [15:0] o_out_value,
    output logic signed [15:0] o_out_mem
);

    sbe_pkg::t_cmd w_cmd;
    sbe_pkg::t_sts w_sts;

    sbe_dp #(
        .STACK_DEPTH(STACK_DEPTH),
        .DATA_WORDS (DATA_WORDS),
        .CODE_BYTES (CODE_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_type (i_req_type),
        .i_arg      (i_arg),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_next_ip  (o_next_ip),
        .o_status   (o_status),
        .o_out_kind (o_out_kind),
        .o_out_value(o_out_value),
        .o_out_mem  (o_out_mem)
    );

    sbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

endmodule

// ===== hw/rtl/sbe_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sbe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== hw/rtl/sbe_ctrl.sv =====
// Controller state machine of the stack bytecode executor.
// Depends on sbe_pkg.
`timescale 1ns / 1ps

module sbe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  sbe_pkg::t_sts i_sts,
    output sbe_pkg::t_cmd o_cmd
);

    sbe_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbe_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            sbe_pkg::S_CLEAR: begin
                o_cmd.clr_mem = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = sbe_pkg::S_IDLE;
                end
            end
            sbe_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = sbe_pkg::S_RD0;
                end
            end
            sbe_pkg::S_RD0: begin
                if (i_sts.halted || i_sts.pre_err) begin
                    o_cmd.fault = ~i_sts.halted;
                    n_state = sbe_pkg::S_OUT;
                end else begin
                    // address memory word read is issued here too
                    o_cmd.rd_stack = 1'b1;
                    o_cmd.rd_depth = 2'd0;
                    n_state = (i_sts.pops > 2'd1) ? sbe_pkg::S_RD1 : sbe_pkg::S_WAITRD;
                end
            end
            sbe_pkg::S_RD1: begin
                o_cmd.rd_stack = 1'b1;
                o_cmd.rd_depth = 2'd1;
                o_cmd.cap_a = 1'b1;
                n_state = (i_sts.pops > 2'd2) ? sbe_pkg::S_RD2 : sbe_pkg::S_WAITRD;
            end
            sbe_pkg::S_RD2: begin
                o_cmd.rd_stack = 1'b1;
                o_cmd.rd_depth = 2'd2;
                o_cmd.cap_b = 1'b1;
                n_state = sbe_pkg::S_WAITRD;
            end
            sbe_pkg::S_WAITRD: begin
                // last stack read lands; capture into the matching operand
                o_cmd.cap_mem = 1'b1;
                o_cmd.cap_a = (i_sts.pops == 2'd1);
                o_cmd.cap_b = (i_sts.pops == 2'd2);
                o_cmd.cap_c = (i_sts.pops == 2'd3);
                n_state = sbe_pkg::S_CHECK;
            end
            sbe_pkg::S_CHECK: begin
                if (i_sts.post_err) begin
                    o_cmd.fault = 1'b1;
                    n_state = sbe_pkg::S_OUT;
                end else if (i_sts.needs_iter) begin
                    o_cmd.iter_start = 1'b1;
                    n_state = sbe_pkg::S_ITER;
                end else begin
                    n_state = sbe_pkg::S_EXEC;
                end
            end
            sbe_pkg::S_ITER: begin
                o_cmd.iter_step = 1'b1;
                if (i_sts.iter_done) begin
                    n_state = sbe_pkg::S_EXEC;
                end
            end
            sbe_pkg::S_EXEC: begin
                o_cmd.commit = 1'b1;
                n_state = sbe_pkg::S_OUT;
            end
            sbe_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = sbe_pkg::S_IDLE;
                end
            end
            default: n_state = sbe_pkg::S_CLEAR;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input and output open together");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == sbe_pkg::S_RD0))
        else $error("accepted beat did not start execution");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("commit not followed by result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.commit, o_cmd.fault, o_cmd.load}))
        else $error("conflicting commands");

endmodule

// ===== hw/rtl/sbe_dp.sv =====
// Datapath of the stack bytecode executor: stack and data memories, operand
// registers, multiplier, square-and-multiply power, restoring divider, result register.
// Depends on sbe_pkg and sbe_ram.
`timescale 1ns / 1ps

module sbe_dp #(
    parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WORDS  = sbe_pkg::DATA_WORDS_DEF,
    parameter int CODE_BYTES  = sbe_pkg::CODE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_req_type,
    input  logic [15:0]        i_arg,
    input  sbe_pkg::t_cmd      i_cmd,
    output sbe_pkg::t_sts      o_sts,
    output logic [9:0]         o_next_ip,
    output logic [3:0]         o_status,
    output logic [2:0]         o_out_kind,
    output logic signed [15:0] o_out_value,
    output logic signed [15:0] o_out_mem
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SLW = $clog2(STACK_DEPTH + 1);
    localparam int DAW = $clog2(DATA_WORDS);
    localparam int PCW = $clog2(CODE_BYTES);

    // instruction and machine state
    logic [7:0]        r_op;
    logic [15:0]       r_arg;
    logic [SLW-1:0]    r_sp;
    logic [PCW-1:0]    r_pc;
    logic [3:0]        r_halt;
    logic [DAW:0]      r_clr;
    logic signed [15:0] r_a, r_b, r_c, r_mword;

    sbe_pkg::t_opinfo w_d;
    assign w_d = sbe_pkg::op_decode(r_op);

    // stack RAM
    logic           w_s_we;
    logic [SAW-1:0] w_s_addr;
    logic [15:0]    w_s_wdata, w_s_rdata;
    logic [SLW-1:0] w_s_idx;

    sbe_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_s_we),
        .i_addr (w_s_addr),
        .i_wdata(w_s_wdata),
        .o_rdata(w_s_rdata)
    );

    // data RAM
    logic           w_d_we;
    logic [DAW-1:0] w_d_addr;
    logic [15:0]    w_d_wdata, w_d_rdata;

    sbe_ram #(.WIDTH(16), .DEPTH(DATA_WORDS)) u_data (
        .i_clk  (i_clk),
        .i_we   (w_d_we),
        .i_addr (w_d_addr),
        .i_wdata(w_d_wdata),
        .o_rdata(w_d_rdata)
    );

    // iterative unit: divider (16 steps) or square-and-multiply power
    logic        r_is_div;
    logic [4:0]  r_cnt;
    logic [15:0] r_q, r_rem, r_dvs, r_acc, r_base, r_exp;
    logic        r_qneg, r_rneg;
    logic [16:0] w_trial;
    logic [15:0] w_rem_sh;
    logic [31:0] w_mul_acc, w_mul_base;

    assign w_rem_sh   = {r_rem[14:0], r_q[15]};
    assign w_trial    = {1'b0, w_rem_sh} - {1'b0, r_dvs};
    assign w_mul_acc  = r_acc * r_base;
    assign w_mul_base = r_base * r_base;

    logic [15:0] w_abs_a, w_abs_b;
    assign w_abs_a = r_a[15] ? 16'(-r_a) : 16'(r_a);
    assign w_abs_b = r_b[15] ? 16'(-r_b) : 16'(r_b);

    // fault checks
    logic [SLW+1:0] w_need;
    logic           w_unf, w_ovf, w_badaddr;
    logic [3:0]     w_pre_code, w_post_code;
    logic [7:0]     w_lo;

    assign w_lo   = r_arg[7:0];
    assign w_unf  = r_sp < SLW'(w_d.pops);
    assign w_need = (SLW+2)'(r_sp) - (SLW+2)'(w_d.pops) + (SLW+2)'(w_d.push);
    assign w_ovf  = w_need > (SLW+2)'(STACK_DEPTH);
    assign w_badaddr = w_d.uses_addr && (17'(r_arg) >= 17'(DATA_WORDS));

    always_comb begin
        w_pre_code = sbe_pkg::ST_RUN;
        if (!w_d.valid) w_pre_code = sbe_pkg::ST_OPC;
        else if (w_unf) w_pre_code = sbe_pkg::ST_UNF;
        else if (w_ovf) w_pre_code = sbe_pkg::ST_OVF;
        else if (w_badaddr) w_pre_code = sbe_pkg::ST_ADDR;
    end

    always_comb begin
        w_post_code = sbe_pkg::ST_RUN;
        if ((r_op == sbe_pkg::OPC_DIV || r_op == sbe_pkg::OPC_DVSBL ||
             r_op == sbe_pkg::OPC_REM) && r_a == 16'sd0)
            w_post_code = sbe_pkg::ST_ZDIV;
        else if (r_op == sbe_pkg::OPC_BOOL && w_lo != sbe_pkg::BOOL_TRUE &&
                 w_lo != sbe_pkg::BOOL_FALSE)
            w_post_code = sbe_pkg::ST_BOOL;
        else if (r_op == sbe_pkg::OPC_NOT && r_a != 16'sd0 && r_a != 16'sd1)
            w_post_code = sbe_pkg::ST_NEG;
        else if (r_op == sbe_pkg::OPC_STOP)
            w_post_code = sbe_pkg::ST_STOP;
    end

    logic w_is_div_op;
    assign w_is_div_op = (r_op == sbe_pkg::OPC_DIV || r_op == sbe_pkg::OPC_DVSBL ||
                          r_op == sbe_pkg::OPC_REM);

    assign o_sts.clr_done  = r_clr[DAW];
    assign o_sts.halted    = r_halt != sbe_pkg::ST_RUN;
    assign o_sts.pre_err   = w_pre_code != sbe_pkg::ST_RUN;
    assign o_sts.post_err  = w_post_code != sbe_pkg::ST_RUN;
    assign o_sts.needs_iter = w_is_div_op || (r_op == sbe_pkg::OPC_POW && !r_a[15]);
    assign o_sts.iter_done = r_is_div ? (r_cnt == 5'd16) : (r_exp == 16'd0);
    assign o_sts.pops      = w_d.pops;

    // memory addressing
    always_comb begin
        w_s_idx   = r_sp - SLW'(1) - SLW'(i_cmd.rd_depth);
        w_s_we    = 1'b0;
        w_s_addr  = w_s_idx[SAW-1:0];
        w_s_wdata = w_res;
        w_d_we    = 1'b0;
        w_d_addr  = r_arg[DAW-1:0];
        w_d_wdata = 16'(r_a);
        if (i_cmd.clr_mem) begin
            w_d_we    = ~r_clr[DAW];
            w_d_addr  = r_clr[DAW-1:0];
            w_d_wdata = '0;
        end else if (i_cmd.commit) begin
            w_s_addr = w_pidx[SAW-1:0];
            w_s_we   = w_d.push;
            if (r_op == sbe_pkg::OPC_SET) w_d_we = 1'b1;
            if (r_op == sbe_pkg::OPC_CHG) begin
                w_d_we = 1'b1;
                w_d_wdata = 16'(r_mword + r_a);
            end
        end
    end

    logic [SLW-1:0] w_pidx;
    assign w_pidx = r_sp - SLW'(w_d.pops);

    // result
    logic [15:0] w_res;
    logic [15:0] w_quo, w_rmd;
    assign w_quo = r_qneg ? 16'(-r_q) : r_q;
    assign w_rmd = r_rneg ? 16'(-r_rem) : r_rem;

    function automatic logic [15:0] tf(input logic t);
        return t ? 16'd0 : 16'd1;
    endfunction

    always_comb begin
        case (r_op)
            sbe_pkg::OPC_PUSH:   w_res = r_arg;
            sbe_pkg::OPC_ADD:    w_res = 16'(r_a + r_b);
            sbe_pkg::OPC_SUB:    w_res = 16'(r_b - r_a);
            sbe_pkg::OPC_MUL:    w_res = r_acc;
            sbe_pkg::OPC_DIV:    w_res = w_quo;
            sbe_pkg::OPC_POW:    w_res = r_acc;
            sbe_pkg::OPC_ABS:    w_res = w_abs_a;
            sbe_pkg::OPC_NEG:    w_res = 16'(-r_a);
            sbe_pkg::OPC_EVEN:   w_res = tf(!r_a[0]);
            sbe_pkg::OPC_ODD:    w_res = tf(r_a[0] && !r_a[15]);
            sbe_pkg::OPC_NONNEG: w_res = tf(!r_a[15]);
            sbe_pkg::OPC_ISNEG:  w_res = tf(r_a[15]);
            sbe_pkg::OPC_DVSBL:  w_res = tf(r_rem == 16'd0);
            sbe_pkg::OPC_REM:    w_res = w_rmd;
            sbe_pkg::OPC_CLAMP:  w_res = (r_c > r_a) ? r_a : ((r_c < r_b) ? r_b : r_c);
            sbe_pkg::OPC_RAND:   w_res = 16'd2;
            sbe_pkg::OPC_EQ:     w_res = tf(r_b == r_a);
            sbe_pkg::OPC_NE:     w_res = tf(r_b != r_a);
            sbe_pkg::OPC_LT:     w_res = tf(r_b < r_a);
            sbe_pkg::OPC_LE:     w_res = tf(r_b <= r_a);
            sbe_pkg::OPC_GT:     w_res = tf(r_b > r_a);
            sbe_pkg::OPC_GE:     w_res = tf(r_b >= r_a);
            sbe_pkg::OPC_NOT:    w_res = tf(r_a != 16'sd0);
            sbe_pkg::OPC_NULL:   w_res = 16'hFFFF;
            sbe_pkg::OPC_GET:    w_res = r_mword;
            sbe_pkg::OPC_BOOL:   w_res = tf(w_lo == sbe_pkg::BOOL_TRUE);
            sbe_pkg::OPC_AND:    w_res = tf(r_a == 16'sd0 && r_b == 16'sd0);
            sbe_pkg::OPC_OR:     w_res = tf(r_a == 16'sd0 || r_b == 16'sd0);
            default:             w_res = 16'd0;
        endcase
    end

    // negative exponent power result
    logic [15:0] w_pow_neg;
    assign w_pow_neg = (r_b == 16'sd1) ? 16'd1 :
                       (r_b == -16'sd1) ? (r_a[0] ? 16'hFFFF : 16'd1) : 16'd0;

    // next fetch address
    logic [16:0] w_next;
    logic        w_taken;
    assign w_taken = (r_op == sbe_pkg::OPC_JMP) ||
                     (r_op == sbe_pkg::OPC_JZ && r_a == 16'sd0) ||
                     (r_op == sbe_pkg::OPC_JNZ && r_a != 16'sd0);
    assign w_next = w_taken ? 17'(r_arg) + 17'd1 : 17'(r_pc) + 17'(w_d.len);

    logic [2:0] w_kind;
    logic       w_has_val, w_has_mem;
    always_comb begin
        w_kind = sbe_pkg::K_NONE;
        case (r_op)
            sbe_pkg::OPC_PRINT: w_kind = sbe_pkg::K_PRINT;
            sbe_pkg::OPC_PINM:  w_kind = sbe_pkg::K_PINM;
            sbe_pkg::OPC_DRD:   w_kind = sbe_pkg::K_DRD;
            sbe_pkg::OPC_DWR:   w_kind = sbe_pkg::K_DWR;
            sbe_pkg::OPC_ARD:   w_kind = sbe_pkg::K_ARD;
            sbe_pkg::OPC_AWR:   w_kind = sbe_pkg::K_AWR;
            sbe_pkg::OPC_DELAY: w_kind = sbe_pkg::K_DELAY;
            default:            w_kind = sbe_pkg::K_NONE;
        endcase
    end
    assign w_has_val = w_kind != sbe_pkg::K_NONE && w_kind != sbe_pkg::K_DRD &&
                       w_kind != sbe_pkg::K_ARD;
    assign w_has_mem = w_kind != sbe_pkg::K_NONE && w_kind != sbe_pkg::K_PRINT &&
                       w_kind != sbe_pkg::K_DELAY;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= '0;
            r_pc   <= '0;
            r_halt <= sbe_pkg::ST_RUN;
            r_clr  <= '0;
        end else begin
            if (i_cmd.clr_mem && !r_clr[DAW]) r_clr <= r_clr + 1'b1;
            if (i_cmd.fault) begin
                r_halt <= o_sts.pre_err ? w_pre_code : w_post_code;
            end
            if (i_cmd.commit) begin
                r_sp <= w_pidx + SLW'(w_d.push);
                if (w_next >= 17'(CODE_BYTES)) r_halt <= sbe_pkg::ST_END;
                else r_pc <= w_next[PCW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_req_type;
            r_arg <= i_arg;
            r_a   <= '0;
            r_b   <= '0;
            r_c   <= '0;
            o_next_ip   <= 10'(r_pc);
            o_status    <= r_halt;
            o_out_kind  <= sbe_pkg::K_NONE;
            o_out_value <= '0;
            o_out_mem   <= '0;
        end
        if (i_cmd.cap_a) r_a <= w_s_rdata;
        if (i_cmd.cap_b) r_b <= w_s_rdata;
        if (i_cmd.cap_c) r_c <= w_s_rdata;
        if (i_cmd.cap_mem) r_mword <= w_d_rdata;
        if (i_cmd.fault) begin
            o_status <= o_sts.pre_err ? w_pre_code : w_post_code;
        end
        if (i_cmd.iter_start) begin
            r_is_div <= w_is_div_op;
            r_cnt    <= '0;
            r_q      <= w_abs_b;
            r_rem    <= '0;
            r_dvs    <= w_abs_a;
            r_qneg   <= r_a[15] ^ r_b[15];
            r_rneg   <= r_b[15];
            r_acc    <= 16'd1;
            r_base   <= r_b;
            r_exp    <= r_a;
        end else if (i_cmd.iter_step) begin
            if (r_is_div) begin
                if (r_cnt != 5'd16) begin
                    r_cnt <= r_cnt + 5'd1;
                    if (!w_trial[16]) begin
                        r_rem <= w_trial[15:0];
                        r_q   <= {r_q[14:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_q   <= {r_q[14:0], 1'b0};
                    end
                end
            end else if (r_exp != 16'd0) begin
                if (r_exp[0]) r_acc <= w_mul_acc[15:0];
                r_base <= w_mul_base[15:0];
                r_exp  <= {1'b0, r_exp[15:1]};
            end
        end
        if (i_cmd.commit) begin
            o_out_kind  <= w_kind;
            o_out_value <= w_has_val ? r_a : 16'sd0;
            o_out_mem   <= w_has_mem ? r_mword : 16'sd0;
            if (w_next >= 17'(CODE_BYTES)) begin
                o_status <= sbe_pkg::ST_END;
            end else begin
                o_next_ip <= 10'(w_next);
            end
        end
        // multiply result, and negative-exponent power, set up in r_acc before commit
        if (i_cmd.cap_mem || i_cmd.cap_a || i_cmd.cap_b) begin
            r_acc <= r_acc;
        end
        if (o_sts.post_err == 1'b0 && !i_cmd.iter_start && !i_cmd.iter_step &&
            !i_cmd.commit && !i_cmd.load) begin
            if (r_op == sbe_pkg::OPC_MUL) r_acc <= w_mul_ab[15:0];
            else if (r_op == sbe_pkg::OPC_POW && r_a[15]) r_acc <= w_pow_neg;
        end
    end

    logic [31:0] w_mul_ab;
    assign w_mul_ab = 16'(r_a) * 16'(r_b);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (r_halt == sbe_pkg::ST_RUN))
        else $error("commit while halted");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_sp <= SLW'(STACK_DEPTH)))
        else $error("stack level beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fault |=> (r_halt != sbe_pkg::ST_RUN))
        else $error("fault did not halt");

endmodule
